// ===== src/sha1md_pkg.sv =====
// Shared types, constants and command/status structs for the SHA-1 digest block.
package sha1md_pkg;

   typedef logic [31:0] word_type;
   typedef word_type    hash_type [5];
   typedef word_type    block_type [16];

   // Operation codes on the request channel
   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam hash_type INIT_HASH = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type ROUND_K [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam int         ROUNDS     = 80;
   localparam logic [5:0] LAST_BYTE  = 6'd63;
   localparam logic [5:0] LEN_START  = 6'd56;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_byte;
      logic pad_first;
      logic pad_second;
      logic init_work;
      logic round;
      logic fold;
      logic capture;
      logic restart;
   } sha1md_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic block_full;
      logic long_tail;
      logic round_last;
   } sha1md_sts_type;

endpackage

// ===== src/sha1md_ifs.sv =====
// Request and response channel interfaces of the SHA-1 digest block.
interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word0;
   logic [31:0] digest_word1;
   logic [31:0] digest_word2;
   logic [31:0] digest_word3;
   logic [31:0] digest_word4;

   modport source (output valid, output digest_word0, output digest_word1,
                   output digest_word2, output digest_word3, output digest_word4,
                   input ready);
   modport sink   (input valid, input digest_word0, input digest_word1,
                   input digest_word2, input digest_word3, input digest_word4,
                   output ready);
endinterface

// ===== src/sha1_message_digest.sv =====
// SHA-1 message digest engine: top level joining controller and datapath.
//
// Request channel (req_bus): each beat carries operation and data_byte.
// operation absorb adds data_byte to the message; operation finish pads the
// message, appends its 64-bit bit length and produces the digest.
// Response channel (rsp_bus): one beat per finish, carrying the five 32-bit
// digest words, word0 holding the first digest bytes.
// Timing: an absorb beat is taken whenever the block is idle. The beat that fills a 64-byte block
// starts the compression: 80 rounds on one round unit, one round per cycle,
// then a fold into the chaining words; no new beat is taken until the fold is
// done. A finish runs the compression before loading the result register, and
// runs it twice when 56 or more bytes were buffered and a second block is needed.
// The sustained byte rate is set by the single round unit.
// The result sits in an output register; absorb beats are taken while it waits.
// A stalled receiver only holds up the next finish before its result is loaded.
// Reset (synchronous, active high) loads the initial hash values, clears the
// byte position and bit counter, and drops any pending result. After each
// finish the block returns to the same state, ready for a new message.
module sha1_message_digest (
   input  logic          clock,
   input  logic          reset,
   sha1md_req_if.sink    req_bus,
   sha1md_rsp_if.source  rsp_bus
);
   import sha1md_pkg::*;

   sha1md_cmd_type cmd;
   sha1md_sts_type sts;
   hash_type       digest;

   sha1md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .operation (req_bus.operation),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha1md_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_bus.data_byte),
      .cmd       (cmd),
      .sts       (sts),
      .digest    (digest)
   );

   // Present the digest words
   assign rsp_bus.digest_word0 = digest[0];
   assign rsp_bus.digest_word1 = digest[1];
   assign rsp_bus.digest_word2 = digest[2];
   assign rsp_bus.digest_word3 = digest[3];
   assign rsp_bus.digest_word4 = digest[4];

endmodule

// ===== src/sha1md_datapath.sv =====
// Datapath: block buffer and schedule, round unit, chaining words, counters, digest register.
module sha1md_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              data_byte,
   input  sha1md_pkg::sha1md_cmd_type cmd,
   output sha1md_pkg::sha1md_sts_type sts,
   output sha1md_pkg::hash_type    digest
);
   import sha1md_pkg::*;

   hash_type    chain_ff, chain_in;
   hash_type    work_ff, work_in;
   hash_type    digest_ff, digest_in;
   block_type   block_ff, block_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] count_ff, count_in;
   logic [6:0]  round_ff, round_in;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
         pos_ff   <= '0;
         count_ff <= '0;
         round_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         round_ff <= round_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      block_ff  <= block_in;
      work_ff   <= work_in;
      digest_ff <= digest_in;
   end

   always_comb begin
      logic [5:0]  q;
      logic [1:0]  stage;
      word_type    f;
      word_type    sched;
      word_type    a, b, c, d, e;

      chain_in  = chain_ff;
      work_in   = work_ff;
      digest_in = digest_ff;
      block_in  = block_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      round_in  = round_ff;

      a = work_ff[0];
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      e = work_ff[4];

      // Pick round group
      if (round_ff < 7'd20)      stage = 2'd0;
      else if (round_ff < 7'd40) stage = 2'd1;
      else if (round_ff < 7'd60) stage = 2'd2;
      else                       stage = 2'd3;

      case (stage)
         2'd0:    f = (b & c) | (~b & d);
         2'd2:    f = (b & c) | (b & d) | (c & d);
         default: f = b ^ c ^ d;
      endcase

      sched = block_ff[13] ^ block_ff[8] ^ block_ff[2] ^ block_ff[0];

      // Pack one byte big-endian into the buffer
      if (cmd.load_byte) begin
         block_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = data_byte;
         pos_in   = pos_ff + 6'd1;
         count_in = count_ff + 64'd8;
      end

      // Append the pad marker and clear the tail; add length if it fits
      if (cmd.pad_first) begin
         for (int i = 0; i < 64; i++) begin
            q = 6'(i);
            if (q == pos_ff) begin
               block_in[q[5:2]][{~q[1:0], 3'b000} +: 8] = PAD_BYTE;
            end else if (q > pos_ff) begin
               block_in[q[5:2]][{~q[1:0], 3'b000} +: 8] = 8'h00;
            end
         end
         if (pos_ff < LEN_START) begin
            block_in[14] = count_ff[63:32];
            block_in[15] = count_ff[31:0];
         end
      end

      // Length-only block for a long tail
      if (cmd.pad_second) begin
         for (int i = 0; i < 14; i++) begin
            block_in[i] = '0;
         end
         block_in[14] = count_ff[63:32];
         block_in[15] = count_ff[31:0];
      end

      if (cmd.init_work) begin
         work_in  = chain_ff;
         round_in = '0;
      end

      // One round; advance the schedule window
      if (cmd.round) begin
         work_in[0] = {a[26:0], a[31:27]} + f + e + block_ff[0] + ROUND_K[stage];
         work_in[1] = a;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[3] = c;
         work_in[4] = d;
         for (int i = 0; i < 15; i++) begin
            block_in[i] = block_ff[i + 1];
         end
         block_in[15] = {sched[30:0], sched[31]};
         round_in     = round_ff + 7'd1;
      end

      if (cmd.fold) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end

      if (cmd.capture) begin
         digest_in = chain_ff;
      end

      // Return to the initial hash for the next message
      if (cmd.restart) begin
         chain_in = INIT_HASH;
         pos_in   = '0;
         count_in = '0;
      end
   end

   assign sts.block_full = (pos_ff == LAST_BYTE);
   assign sts.long_tail  = (pos_ff >= LEN_START);
   assign sts.round_last = (round_ff == 7'(ROUNDS - 1));
   assign digest         = digest_ff;

endmodule

// ===== src/sha1md_ctrl.sv =====
// Controller: sequences byte loads, padding, compression rounds, folding and result output.
module sha1md_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    operation,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  sha1md_pkg::sha1md_sts_type sts,
   output sha1md_pkg::sha1md_cmd_type cmd
);
   import sha1md_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_FOLD,
      S_PAD2,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      finish_ff, finish_in;
   logic      second_ff, second_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         finish_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         finish_ff    <= finish_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      finish_in    = finish_ff;
      second_in    = second_ff;
      // Drop the result once the sink takes it
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (operation == OP_FINISH) begin
                  cmd.pad_first = 1'b1;
                  cmd.init_work = 1'b1;
                  finish_in     = 1'b1;
                  second_in     = sts.long_tail;
                  state_in      = S_ROUND;
               end else begin
                  cmd.load_byte = 1'b1;
                  if (sts.block_full) begin
                     cmd.init_work = 1'b1;
                     state_in      = S_ROUND;
                  end
               end
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (!finish_ff)     state_in = S_IDLE;
            else if (second_ff) state_in = S_PAD2;
            else                state_in = S_OUT;
         end
         S_PAD2: begin
            cmd.pad_second = 1'b1;
            cmd.init_work  = 1'b1;
            second_in      = 1'b0;
            state_in       = S_ROUND;
         end
         S_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture  = 1'b1;
               cmd.restart  = 1'b1;
               rsp_valid_in = 1'b1;
               finish_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
